// ===== design/mbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_pkg: shared types and constants
// Widths of the fixed fields, register indexes, sequencer states and the
// multiplier request bundle.
// ----------------------------------------------------------------------------
package mbc_pkg;

   localparam int PIX_W      = 10;
   localparam int STEP_W     = 47;
   localparam int ORG_W      = 48;
   localparam int ITER_W     = 16;
   localparam int CH_W       = 8;
   localparam int HUE_W      = 5;
   localparam int SUM_W      = 7;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 48;
   localparam int TDATA_W    = 24;

   // (2p+o) * step, and the sample coordinate after adding the origin
   localparam int PROD_W     = PIX_W + 1 + STEP_W;
   localparam int CW         = PROD_W + 1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_PIXEL_STEP = 2'd0,
      REG_ORIGIN_X   = 2'd1,
      REG_ORIGIN_Y   = 2'd2,
      REG_MAX_ITER   = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COORD,
      ST_ORIGIN,
      ST_CHECK,
      ST_UPDATE,
      ST_ESCAPE,
      ST_MUL_X2,
      ST_MUL_Y2,
      ST_TEST,
      ST_MUL_XY,
      ST_HUE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic half_shift;   // shift by FRAC_BITS-1 instead of FRAC_BITS
      logic neg;          // negate with floor rounding
   } mul_req_type;

endpackage
`default_nettype wire

// ===== design/mbc_fx_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_fx_mul: multicycle fixed-point multiplier
// Two-digit by two-digit magnitude product, one partial product per cycle,
// then a floor-rounded shift and optional negation.
// ----------------------------------------------------------------------------
module mbc_fx_mul #(
   parameter int FRAC_BITS = 44
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mbc_pkg::mul_req_type        req,
   input  wire logic [FRAC_BITS+1:0]        a,
   input  wire logic [FRAC_BITS+1:0]        b,
   output logic                             done,
   output logic signed [FRAC_BITS+4:0]      result
);

   localparam int MAG_W = FRAC_BITS + 2;
   localparam int DIG_W = (MAG_W + 1) / 2;
   localparam int OPD_W = 2 * DIG_W;
   localparam int PW    = 2 * OPD_W;
   localparam int RW    = FRAC_BITS + 5;

   logic [OPD_W-1:0]     a_ff, a_in, b_ff, b_in;
   logic                 half_ff, half_in, neg_ff, neg_in;
   logic [2:0]           step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic [OPD_W-1:0]     pp_ff, pp_in;
   logic [1:0]           wt_ff, wt_in;
   logic                 pp_vld_ff, pp_vld_in;
   logic [PW-1:0]        acc_ff, acc_in;
   logic                 done_ff, done_in;
   logic signed [RW-1:0] result_ff, result_in;

   logic [DIG_W-1:0]     dig_a, dig_b;
   logic [PW-1:0]        pp_shifted, q_full, lo_mask;
   logic                 rem;
   logic signed [RW-1:0] q;

   always_comb begin
      dig_a = step_ff[1] ? a_ff[OPD_W-1:DIG_W] : a_ff[DIG_W-1:0];
      dig_b = step_ff[0] ? b_ff[OPD_W-1:DIG_W] : b_ff[DIG_W-1:0];

      case (wt_ff)
         2'd0:    pp_shifted = PW'(pp_ff);
         2'd1:    pp_shifted = PW'(pp_ff) << DIG_W;
         2'd2:    pp_shifted = PW'(pp_ff) << (2 * DIG_W);
         default: pp_shifted = '0;
      endcase

      if (half_ff) begin
         q_full  = acc_ff >> (FRAC_BITS - 1);
         lo_mask = (PW'(1) << (FRAC_BITS - 1)) - PW'(1);
      end else begin
         q_full  = acc_ff >> FRAC_BITS;
         lo_mask = (PW'(1) << FRAC_BITS) - PW'(1);
      end
      rem = |(acc_ff & lo_mask);
      q   = signed'(q_full[RW-1:0]);
   end

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      half_in   = half_ff;
      neg_in    = neg_ff;
      step_in   = step_ff;
      busy_in   = busy_ff;
      pp_in     = pp_ff;
      wt_in     = wt_ff;
      pp_vld_in = 1'b0;
      acc_in    = acc_ff;
      done_in   = 1'b0;
      result_in = result_ff;

      if (req.start) begin
         a_in    = OPD_W'(a);
         b_in    = OPD_W'(b);
         half_in = req.half_shift;
         neg_in  = req.neg;
         step_in = '0;
         busy_in = 1'b1;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (step_ff < 3'd4) begin
            pp_in     = dig_a * dig_b;
            wt_in     = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
            pp_vld_in = 1'b1;
         end
         if (pp_vld_ff) begin
            acc_in = acc_ff + pp_shifted;
         end
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd5) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            result_in = neg_ff ? (-q - RW'(rem)) : q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         pp_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         busy_ff   <= busy_in;
         pp_vld_ff <= pp_vld_in;
         done_ff   <= done_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      half_ff   <= half_in;
      neg_ff    <= neg_in;
      pp_ff     <= pp_in;
      wt_ff     <= wt_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule
`default_nettype wire

// ===== design/mandelbrot_ssaa_pixel_colour_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_ssaa_pixel_colour_unit: supersampled escape-time pixel colour
// One pixel request in, one RGB response out, four subsamples per pixel.
// ----------------------------------------------------------------------------
// One request carries a pixel (x, y); the unit places four subsamples at
// half-pixel offsets, iterates z = z*z + c for each in signed fixed point
// with FRAC_BITS fraction bits, maps each escape count to a hue and returns
// the rounded 2x2 average. Pixels outside RES_X x RES_Y return black at once.
// All squaring goes through one shared multiplier that builds a product from
// four digit products. One surviving iteration of one subsample runs three
// products (x*x, y*y and 2*x*y) plus check, update, escape and test steps. A
// subsample ends when its count reaches the iteration limit (max_iter), when
// a component exceeds 2, or when the squared magnitude exceeds 4. A new request
// is taken only in the idle state, at the earliest in the same cycle that the
// previous response becomes valid; a finished response waits in an output
// register, so the next pixel can start while the previous response is still
// unread.
// Configuration is written through csr_* and must only change while idle.
module mandelbrot_ssaa_pixel_colour_unit #(
   parameter int RES_X     = 1024,
   parameter int RES_Y     = 1024,
   parameter int FRAC_BITS = 44
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [mbc_pkg::TDATA_W-1:0]         req_tdata,  // pixel_x, pixel_y, pad
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [mbc_pkg::TDATA_W-1:0]              rsp_tdata,  // red, green, blue
   input  wire logic                                csr_wr_en,
   input  wire logic [mbc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [mbc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int MAG_W = FRAC_BITS + 2;
   localparam int RW    = FRAC_BITS + 5;
   localparam int ZW    = ((mbc_pkg::CW > FRAC_BITS + 3) ? mbc_pkg::CW : FRAC_BITS + 3) + 2;
   localparam logic signed [ZW-1:0] TWO  = ZW'(2) << FRAC_BITS;
   localparam logic signed [ZW-1:0] FOUR = ZW'(4) << FRAC_BITS;
   localparam logic [12:0] LIM_X = 13'(RES_X);
   localparam logic [12:0] LIM_Y = 13'(RES_Y);

   // configuration
   logic [mbc_pkg::STEP_W-1:0]        step_ff;
   logic signed [mbc_pkg::ORG_W-1:0]  org_x_ff, org_y_ff;
   logic [mbc_pkg::ITER_W-1:0]        max_iter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= mbc_pkg::STEP_W'(64'h10_0000_0000);
         org_x_ff    <= 48'shE000_0000_0000;
         org_y_ff    <= 48'shE000_0000_0000;
         max_iter_ff <= 16'd100;
      end else if (csr_wr_en) begin
         case (mbc_pkg::reg_index_type'(csr_addr))
            mbc_pkg::REG_PIXEL_STEP: step_ff     <= csr_wdata[mbc_pkg::STEP_W-1:0];
            mbc_pkg::REG_ORIGIN_X:   org_x_ff    <= signed'(csr_wdata);
            mbc_pkg::REG_ORIGIN_Y:   org_y_ff    <= signed'(csr_wdata);
            mbc_pkg::REG_MAX_ITER:   max_iter_ff <= csr_wdata[mbc_pkg::ITER_W-1:0];
            default:                 max_iter_ff <= max_iter_ff;
         endcase
      end
   end

   // sequencer and datapath registers
   mbc_pkg::state_type                state_ff, state_in;
   logic [mbc_pkg::PIX_W-1:0]         px_ff, px_in, py_ff, py_in;
   logic [1:0]                        k_ff, k_in;
   logic [mbc_pkg::PROD_W-1:0]        prodx_ff, prodx_in, prody_ff, prody_in;
   logic signed [mbc_pkg::CW-1:0]     cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ZW-1:0]              zx_ff, zx_in, zy_ff, zy_in;
   logic signed [ZW-1:0]              x2_ff, x2_in, y2_ff, y2_in, xy_ff, xy_in;
   logic [MAG_W-1:0]                  mx_ff, mx_in, my_ff, my_in;
   logic [mbc_pkg::ITER_W-1:0]        n_ff, n_in;
   logic [mbc_pkg::SUM_W-1:0]         sr_ff, sr_in, sg_ff, sg_in, sb_ff, sb_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [mbc_pkg::TDATA_W-1:0]       rsp_data_ff, rsp_data_in;

   // shared multiplier
   mbc_pkg::mul_req_type              mul_req;
   logic [MAG_W-1:0]                  mul_a, mul_b;
   logic                              mul_done;
   logic signed [RW-1:0]              mul_result;

   mbc_fx_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mul_req),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_result)
   );

   // hue of the current escape count, in sixteenths
   function automatic logic [mbc_pkg::HUE_W-1:0] clamp16(input logic signed [8:0] v);
      logic [mbc_pkg::HUE_W-1:0] c;
      if (v < 9'sd0)       c = '0;
      else if (v > 9'sd16) c = 5'd16;
      else                 c = v[mbc_pkg::HUE_W-1:0];
      return c;
   endfunction

   function automatic logic signed [8:0] abs9(input logic signed [8:0] v);
      return (v < 9'sd0) ? -v : v;
   endfunction

   // sum * 255/64, round half to even
   function automatic logic [mbc_pkg::CH_W-1:0] round_ch(input logic [mbc_pkg::SUM_W-1:0] s);
      logic [14:0] p;
      logic [8:0]  q;
      logic [5:0]  r;
      p = {s, 8'b0} - 15'(s);
      q = p[14:6];
      r = p[5:0];
      if (r > 6'd32 || (r == 6'd32 && q[0])) q = q + 9'd1;
      return q[mbc_pkg::CH_W-1:0];
   endfunction

   logic signed [8:0]             f_s;
   logic [mbc_pkg::HUE_W-1:0]     hue_r, hue_g, hue_b;
   logic [ZW-1:0]                 magx, magy;

   always_comb begin
      f_s   = 9'(n_ff[mbc_pkg::HUE_W-1:0]) * 9'sd3;
      hue_r = clamp16(abs9(f_s - 9'sd48) - 9'sd16);
      hue_g = clamp16(9'sd32 - abs9(f_s - 9'sd32));
      hue_b = clamp16(9'sd32 - abs9(f_s - 9'sd64));
      magx  = zx_ff[ZW-1] ? unsigned'(-zx_ff) : unsigned'(zx_ff);
      magy  = zy_ff[ZW-1] ? unsigned'(-zy_ff) : unsigned'(zy_ff);
   end

   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      k_in         = k_ff;
      prodx_in     = prodx_ff;
      prody_in     = prody_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      zx_in        = zx_ff;
      zy_in        = zy_ff;
      x2_in        = x2_ff;
      y2_in        = y2_ff;
      xy_in        = xy_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      n_in         = n_ff;
      sr_in        = sr_ff;
      sg_in        = sg_ff;
      sb_in        = sb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul_req      = '0;
      mul_a        = mx_ff;
      mul_b        = mx_ff;

      case (state_ff)
         mbc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               px_in = req_tdata[mbc_pkg::PIX_W-1:0];
               py_in = req_tdata[2*mbc_pkg::PIX_W-1:mbc_pkg::PIX_W];
               k_in  = '0;
               sr_in = '0;
               sg_in = '0;
               sb_in = '0;
               if (13'(req_tdata[mbc_pkg::PIX_W-1:0]) >= LIM_X ||
                   13'(req_tdata[2*mbc_pkg::PIX_W-1:mbc_pkg::PIX_W]) >= LIM_Y) begin
                  state_in = mbc_pkg::ST_DONE;
               end else begin
                  state_in = mbc_pkg::ST_COORD;
               end
            end
         end
         mbc_pkg::ST_COORD: begin
            prodx_in = mbc_pkg::PROD_W'({px_ff, k_ff[0]}) * mbc_pkg::PROD_W'(step_ff);
            prody_in = mbc_pkg::PROD_W'({py_ff, k_ff[1]}) * mbc_pkg::PROD_W'(step_ff);
            state_in = mbc_pkg::ST_ORIGIN;
         end
         mbc_pkg::ST_ORIGIN: begin
            cx_in    = signed'({2'b00, prodx_ff[mbc_pkg::PROD_W-1:1]}) + mbc_pkg::CW'(org_x_ff);
            cy_in    = signed'({2'b00, prody_ff[mbc_pkg::PROD_W-1:1]}) + mbc_pkg::CW'(org_y_ff);
            zx_in    = '0;
            zy_in    = '0;
            x2_in    = '0;
            y2_in    = '0;
            xy_in    = '0;
            n_in     = '0;
            state_in = mbc_pkg::ST_CHECK;
         end
         mbc_pkg::ST_CHECK: begin
            state_in = (n_ff == max_iter_ff) ? mbc_pkg::ST_HUE : mbc_pkg::ST_UPDATE;
         end
         mbc_pkg::ST_UPDATE: begin
            zx_in    = x2_ff - y2_ff + ZW'(cx_ff);
            zy_in    = xy_ff + ZW'(cy_ff);
            state_in = mbc_pkg::ST_ESCAPE;
         end
         mbc_pkg::ST_ESCAPE: begin
            if (magx > unsigned'(TWO) || magy > unsigned'(TWO)) begin
               state_in = mbc_pkg::ST_HUE;
            end else begin
               mx_in         = magx[MAG_W-1:0];
               my_in         = magy[MAG_W-1:0];
               mul_a         = magx[MAG_W-1:0];
               mul_b         = magx[MAG_W-1:0];
               mul_req.start = 1'b1;
               state_in      = mbc_pkg::ST_MUL_X2;
            end
         end
         mbc_pkg::ST_MUL_X2: begin
            if (mul_done) begin
               x2_in         = ZW'(mul_result);
               mul_a         = my_ff;
               mul_b         = my_ff;
               mul_req.start = 1'b1;
               state_in      = mbc_pkg::ST_MUL_Y2;
            end
         end
         mbc_pkg::ST_MUL_Y2: begin
            if (mul_done) begin
               y2_in    = ZW'(mul_result);
               state_in = mbc_pkg::ST_TEST;
            end
         end
         mbc_pkg::ST_TEST: begin
            if (x2_ff + y2_ff > FOUR) begin
               state_in = mbc_pkg::ST_HUE;
            end else begin
               // survived this iteration; 2*zx*zy for the next one
               n_in               = n_ff + 16'd1;
               mul_a              = mx_ff;
               mul_b              = my_ff;
               mul_req.start      = 1'b1;
               mul_req.half_shift = 1'b1;
               mul_req.neg        = zx_ff[ZW-1] ^ zy_ff[ZW-1];
               state_in           = mbc_pkg::ST_MUL_XY;
            end
         end
         mbc_pkg::ST_MUL_XY: begin
            if (mul_done) begin
               xy_in    = ZW'(mul_result);
               state_in = mbc_pkg::ST_CHECK;
            end
         end
         mbc_pkg::ST_HUE: begin
            // in-set subsamples add black
            if (n_ff != max_iter_ff) begin
               sr_in = sr_ff + mbc_pkg::SUM_W'(hue_r);
               sg_in = sg_ff + mbc_pkg::SUM_W'(hue_g);
               sb_in = sb_ff + mbc_pkg::SUM_W'(hue_b);
            end
            if (k_ff == 2'd3) begin
               state_in = mbc_pkg::ST_DONE;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = mbc_pkg::ST_COORD;
            end
         end
         mbc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {round_ch(sb_ff), round_ch(sg_ff), round_ch(sr_ff)};
               state_in     = mbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mbc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      k_ff        <= k_in;
      prodx_ff    <= prodx_in;
      prody_ff    <= prody_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      zx_ff       <= zx_in;
      zy_ff       <= zy_in;
      x2_ff       <= x2_in;
      y2_ff       <= y2_in;
      xy_ff       <= xy_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      n_ff        <= n_in;
      sr_ff       <= sr_in;
      sg_ff       <= sg_in;
      sb_ff       <= sb_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == mbc_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // multiplier results only come back while the sequencer waits for one
   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == mbc_pkg::ST_MUL_X2 || state_ff == mbc_pkg::ST_MUL_Y2 ||
                    state_ff == mbc_pkg::ST_MUL_XY))
      else $error("multiplier done outside a multiply state");

   // squaring only starts on components that passed the magnitude test
   a_mag_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbc_pkg::ST_MUL_X2) |-> (ZW'(mx_ff) <= TWO && ZW'(my_ff) <= TWO))
      else $error("squaring an escaped component");

   // the cross product is only formed after counting a surviving iteration
   a_count_before_xy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbc_pkg::ST_MUL_XY) |-> (n_ff != '0))
      else $error("cross product without counted iteration");

endmodule
`default_nettype wire

// ===== bench/tb_mandelbrot_ssaa_pixel_colour_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_ssaa_pixel_colour_unit: self-checking bench for the pixel unit
// A directed table of register writes and pixel requests runs first. Random
// pixels under random plane windows and iteration limits follow, under three
// idle/stall patterns. Each response is compared with a typed or modelled colour.
// ----------------------------------------------------------------------------
module tb_mandelbrot_ssaa_pixel_colour_unit;

   localparam int FRAC  = 44;
   localparam int RES_X = 1024;
   localparam int RES_Y = 1024;

   // directed table row kinds
   typedef enum logic {ROW_CSR, ROW_PIX} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      mbc_pkg::reg_index_type idx;
      logic [47:0]            value;
      logic [9:0]             px;
      logic [9:0]             py;
      bit                     typed;   // expected colour typed in below
      logic [23:0]            rgb;     // {blue, green, red}
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [mbc_pkg::TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [mbc_pkg::TDATA_W-1:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [mbc_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [mbc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow copy of the unit's registers
   logic [46:0] step_q;
   logic [47:0] org_x_q, org_y_q;
   logic [15:0] iter_lim_q;

   logic [23:0] colour_q[$];       // colours still owed by the unit
   int send_idle_pct, recv_stall_pct;
   int mismatches, responses, pixels_sent, writes_done;
   int black_seen, deep_pixels;

   mandelbrot_ssaa_pixel_colour_unit dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_wr_en, .csr_addr, .csr_wdata
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // escape count of one sample, 128-bit signed so no product can wrap
   function automatic int unsigned escape_iters(logic signed [127:0] cx,
                                                logic signed [127:0] cy);
      logic signed [127:0] zx, zy, x2, y2, xy, two, four;
      int unsigned n;
      zx = 0;
      zy = 0;
      n = 0;
      two = 128'sd2 <<< FRAC;
      four = 128'sd4 <<< FRAC;
      for (int i = 0; i < iter_lim_q; i++) begin
         x2 = (zx * zx) >>> FRAC;
         y2 = (zy * zy) >>> FRAC;
         xy = (zx * zy) >>> (FRAC - 1);   // 2*zx*zy, floor
         zx = x2 - y2 + cx;
         zy = xy + cy;
         if (zx > two || zx < -two || zy > two || zy < -two) break;
         if (((zx * zx) >>> FRAC) + ((zy * zy) >>> FRAC) > four) break;
         n++;
      end
      return n;
   endfunction

   function automatic logic [7:0] round_chan(int unsigned s);
      int unsigned p, q;
      p = s * 255;
      q = p >> 6;
      if ((p & 63) > 32 || ((p & 63) == 32 && q[0])) q++;
      return q[7:0];
   endfunction

   function automatic int clamp_hue(int v);
      return v < 0 ? 0 : (v > 16 ? 16 : v);
   endfunction

   function automatic int iabs(int v);
      return v < 0 ? -v : v;
   endfunction

   // colour of one pixel under the current shadow registers
   function automatic logic [23:0] pixel_colour(logic [9:0] px, logic [9:0] py);
      logic [127:0] tx, ty;
      logic signed [127:0] cx, cy;
      int unsigned n, sr, sg, sb;
      int f;
      sr = 0;
      sg = 0;
      sb = 0;
      if (int'(px) >= RES_X || int'(py) >= RES_Y) return 24'h0;   // off screen
      for (int k = 0; k < 4; k++) begin
         tx = ((128'(px) * 2 + 128'(k & 1)) * 128'(step_q)) >> 1;
         ty = ((128'(py) * 2 + 128'((k >> 1) & 1)) * 128'(step_q)) >> 1;
         cx = $signed(tx) + {{80{org_x_q[47]}}, org_x_q};
         cy = $signed(ty) + {{80{org_y_q[47]}}, org_y_q};
         n = escape_iters(cx, cy);
         if (n == iter_lim_q) continue;   // inside the set: black sample
         f = 3 * int'(n & 31);            // hue in sixteenths
         sr += clamp_hue(iabs(f - 48) - 16);
         sg += clamp_hue(32 - iabs(f - 32));
         sb += clamp_hue(32 - iabs(f - 64));
      end
      return {round_chan(sb), round_chan(sg), round_chan(sr)};
   endfunction

   // hold off new requests until every owed colour has come back
   task automatic drain_pixels();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (colour_q.size() != 0) @(negedge clock);
   endtask

   // register write; only ever issued with the unit idle
   task automatic write_reg(mbc_pkg::reg_index_type idx, logic [47:0] value);
      drain_pixels();
      csr_wr_en <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      case (idx)
         mbc_pkg::REG_PIXEL_STEP: step_q = value[46:0];
         mbc_pkg::REG_ORIGIN_X: org_x_q = value;
         mbc_pkg::REG_ORIGIN_Y: org_y_q = value;
         default: iter_lim_q = value[15:0];
      endcase
      writes_done++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // idle a random while, then hold the pixel until taken; valid stays high
   // on exit for back-to-back
   task automatic send_pixel(logic [9:0] px, logic [9:0] py, bit typed,
                             logic [23:0] rgb);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, py, px};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      colour_q.push_back(typed ? rgb : pixel_colour(px, py));
      pixels_sent++;
   endtask

   // receiver stall pattern, changed at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      logic [23:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses++;
         if (rsp_tdata == 24'h0) black_seen++;
         if (colour_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected response rgb=%h", $realtime, rsp_tdata);
         end else begin
            want = colour_q.pop_front();
            if (rsp_tdata[7:0] != want[7:0] || rsp_tdata[15:8] != want[15:8] ||
                rsp_tdata[23:16] != want[23:16]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] colour mismatch: red %0d/%0d green %0d/%0d blue %0d/%0d (exp/act)",
                           $realtime, want[7:0], rsp_tdata[7:0], want[15:8],
                           rsp_tdata[15:8], want[23:16], rsp_tdata[23:16]);
            end
         end
      end
   end

   // watchdog
   initial begin
      #200_000_000;
      $display("timeout with %0d colours owed", colour_q.size());
      $display("FAILURE");
      $finish;
   end

   // Directed table. Pixel (0,0) at reset escapes on the first iteration for
   // all samples, hue zero gives pure red; the same holds whenever the origin
   // sits far out of the |c| <= 2 disc. A zero iteration limit is always black.
   row_type dir_rows[] = '{
      '{ROW_PIX, mbc_pkg::REG_PIXEL_STEP, 48'd0, 10'd0, 10'd0, 1'b1, 24'h0000FF},
      '{ROW_PIX, mbc_pkg::REG_PIXEL_STEP, 48'd0, 10'd1023, 10'd1023, 1'b0, 24'h0},
      '{ROW_PIX, mbc_pkg::REG_PIXEL_STEP, 48'd0, 10'd512, 10'd512, 1'b0, 24'h0},
      '{ROW_PIX, mbc_pkg::REG_PIXEL_STEP, 48'd0, 10'd0, 10'd1023, 1'b0, 24'h0},
      '{ROW_PIX, mbc_pkg::REG_PIXEL_STEP, 48'd0, 10'd1023, 10'd0, 1'b0, 24'h0},
      '{ROW_PIX, mbc_pkg::REG_PIXEL_STEP, 48'd0, 10'd340, 10'd700, 1'b0, 24'h0},
      '{ROW_CSR, mbc_pkg::REG_MAX_ITER, 48'd0, 10'd0, 10'd0, 1'b0, 24'h0},
      '{ROW_PIX, mbc_pkg::REG_PIXEL_STEP, 48'd0, 10'd512, 10'd512, 1'b1, 24'h000000},
      '{ROW_PIX, mbc_pkg::REG_PIXEL_STEP, 48'd0, 10'd1023, 10'd1023, 1'b1, 24'h000000},
      '{ROW_CSR, mbc_pkg::REG_MAX_ITER, 48'hFFFF, 10'd0, 10'd0, 1'b0, 24'h0},
      '{ROW_CSR, mbc_pkg::REG_ORIGIN_X, 48'h7FFF_FFFF_FFFF, 10'd0, 10'd0, 1'b0, 24'h0},
      '{ROW_PIX, mbc_pkg::REG_PIXEL_STEP, 48'd0, 10'd0, 10'd0, 1'b1, 24'h0000FF},
      '{ROW_CSR, mbc_pkg::REG_ORIGIN_X, 48'h8000_0000_0000, 10'd0, 10'd0, 1'b0, 24'h0},
      '{ROW_CSR, mbc_pkg::REG_ORIGIN_Y, 48'h8000_0000_0000, 10'd0, 10'd0, 1'b0, 24'h0},
      '{ROW_PIX, mbc_pkg::REG_PIXEL_STEP, 48'd0, 10'd0, 10'd0, 1'b1, 24'h0000FF},
      '{ROW_CSR, mbc_pkg::REG_PIXEL_STEP, 48'h7FFF_FFFF_FFFF, 10'd0, 10'd0, 1'b0, 24'h0},
      '{ROW_PIX, mbc_pkg::REG_PIXEL_STEP, 48'd0, 10'd1023, 10'd1023, 1'b1, 24'h0000FF},
      '{ROW_PIX, mbc_pkg::REG_PIXEL_STEP, 48'd0, 10'd682, 10'd341, 1'b0, 24'h0},
      '{ROW_CSR, mbc_pkg::REG_PIXEL_STEP, 48'd0, 10'd0, 10'd0, 1'b0, 24'h0},
      '{ROW_PIX, mbc_pkg::REG_PIXEL_STEP, 48'd0, 10'd777, 10'd333, 1'b1, 24'h0000FF},
      '{ROW_CSR, mbc_pkg::REG_MAX_ITER, 48'd1, 10'd0, 10'd0, 1'b0, 24'h0},
      '{ROW_CSR, mbc_pkg::REG_ORIGIN_X, 48'h0, 10'd0, 10'd0, 1'b0, 24'h0},
      '{ROW_CSR, mbc_pkg::REG_ORIGIN_Y, 48'h0, 10'd0, 10'd0, 1'b0, 24'h0},
      '{ROW_CSR, mbc_pkg::REG_PIXEL_STEP, 48'h100_0000_0000, 10'd0, 10'd0, 1'b0, 24'h0},
      '{ROW_PIX, mbc_pkg::REG_PIXEL_STEP, 48'd0, 10'd5, 10'd3, 1'b0, 24'h0}
   };

   initial begin
      logic [63:0] r64;
      step_q = 47'h10_0000_0000;            // reset values of the unit
      org_x_q = 48'hE000_0000_0000;
      org_y_q = 48'hE000_0000_0000;
      iter_lim_q = 16'd100;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      mismatches = 0;
      responses = 0;
      pixels_sent = 0;
      writes_done = 0;
      black_seen = 0;
      deep_pixels = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR)
            write_reg(dir_rows[i].idx, dir_rows[i].value);
         else
            send_pixel(dir_rows[i].px, dir_rows[i].py, dir_rows[i].typed,
                       dir_rows[i].rgb);
      end

      // random part: three idle patterns, several plane windows each
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 73 : 0;
         recv_stall_pct = (mode == 0) ? 73 : (mode == 1) ? 7 : 0;
         for (int win = 0; win < 4; win++) begin
            // window around the set, step of varying zoom; now and then raw bits
            r64 = {$urandom, $urandom};
            if ($urandom_range(9) == 0) begin
               write_reg(mbc_pkg::REG_PIXEL_STEP, r64[47:0]);
               write_reg(mbc_pkg::REG_ORIGIN_X, {$urandom, $urandom});
               write_reg(mbc_pkg::REG_ORIGIN_Y, {$urandom, $urandom});
            end else begin
               write_reg(mbc_pkg::REG_PIXEL_STEP,
                         (r64[35:0] >> $urandom_range(0, 8)) | 48'h1);
               write_reg(mbc_pkg::REG_ORIGIN_X, 48'hD800_0000_0000 +
                         ({$urandom, $urandom} % 64'h3000_0000_0000));
               write_reg(mbc_pkg::REG_ORIGIN_Y, 48'hE000_0000_0000 +
                         ({$urandom, $urandom} % 64'h2000_0000_0000));
            end
            // shallow limits keep the run short; an occasional deeper one
            if ($urandom_range(7) == 0) begin
               write_reg(mbc_pkg::REG_MAX_ITER, $urandom_range(12, 24));
               deep_pixels += 1;
            end else begin
               write_reg(mbc_pkg::REG_MAX_ITER, $urandom_range(0, 8));
            end
            repeat (116) send_pixel($urandom_range(1023), $urandom_range(1023),
                                    1'b0, 24'h0);
         end
      end

      drain_pixels();
      repeat (300) @(negedge clock);   // catch any stray response
      $display("covered %0d pixels, %0d register writes, %0d responses (%0d black)",
               pixels_sent, writes_done, responses, black_seen);
      $display("three stall patterns, %0d deeper windows, %0d mismatches",
               deep_pixels, mismatches);
      if (mismatches == 0 && colour_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/mbc_pkg.sv
design/mbc_fx_mul.sv
design/mandelbrot_ssaa_pixel_colour_unit.sv
bench/tb_mandelbrot_ssaa_pixel_colour_unit.sv
